>>> hdl/eds_pkg.sv
package eds_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_OFFSET = 3'd6;

    localparam logic [23:0] KP_RESET     = 24'd786432;
    localparam logic [23:0] KI_RESET     = 24'd7;
    localparam logic [23:0] KD_RESET     = 24'd524288;
    localparam logic [15:0] TARGET_RESET = 16'd2790;
    localparam logic [15:0] AMIN_RESET   = 16'd10240;
    localparam logic [15:0] AMAX_RESET   = 16'd13568;
    localparam logic [7:0]  OFFSET_RESET = 8'd45;
    localparam logic [15:0] ANGLE_RESET  = 16'd11520;

    // floor(count * 256 / 58) == (count * ceil(2^28 / 29)) >> 21 for 16-bit counts
    localparam logic [23:0] DIST_RECIP = 24'd9256396;
    localparam int          DIST_SHIFT = 21;

    localparam int COUNT_W = 16;
    localparam int DIST_W  = 19;
    localparam int ERR_W   = 20;
    localparam int DER_W   = 21;
    localparam int SUM_W   = 40;
    localparam int DRIVE_W = 32;
    localparam int ANGLE_W = 16;
    localparam int CMP_W   = 9;

    typedef struct packed {
        logic [23:0] kp_gain;
        logic [23:0] ki_gain;
        logic [23:0] kd_gain;
        logic [15:0] target_distance;
        logic [15:0] angle_min;
        logic [15:0] angle_max;
        logic [7:0]  servo_offset;
    } t_cfg;

endpackage

>>> hdl/eds_dist.sv
module eds_dist
    import eds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COUNT_W-1:0] i_count,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [DIST_W-1:0]  o_dist
);

    logic              r_valid;
    logic [DIST_W-1:0] r_dist;
    logic [39:0]       w_prod;
    logic              w_en;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;
    assign w_prod  = {24'd0, i_count} * {16'd0, DIST_RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_dist <= w_prod[DIST_SHIFT+DIST_W-1:DIST_SHIFT];
        end
    end

    assign o_valid = r_valid;
    assign o_dist  = r_dist;

endmodule

>>> hdl/eds_pid.sv
module eds_pid
    import eds_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [DIST_W-1:0]         i_dist,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [DIST_W-1:0]         o_dist,
    output logic signed [DRIVE_W-1:0] o_drive
);

    localparam logic signed [SUM_W:0] SUM_MAX = 41'sd549755813887;
    localparam logic signed [SUM_W:0] SUM_MIN = -41'sd549755813888;
    localparam logic signed [50:0]    DRV_MAX = 51'sd2147483647;
    localparam logic signed [50:0]    DRV_MIN = -51'sd2147483648;

    // integrator state
    logic signed [SUM_W-1:0] r_error_sum;
    logic signed [ERR_W-1:0] r_prev_error;

    logic r_v2, r_v3, r_v4;
    logic w_en2, w_en3, w_en4;

    // stage 2: error, integral, derivative
    logic signed [ERR_W:0]   w_err_full;
    logic signed [ERR_W-1:0] w_err;
    logic signed [SUM_W:0]   w_sum_full;
    logic signed [SUM_W-1:0] n_error_sum;
    logic signed [DER_W-1:0] w_der;

    logic [DIST_W-1:0]       r2_dist;
    logic signed [ERR_W-1:0] r2_err;
    logic signed [SUM_W-1:0] r2_sum;
    logic signed [DER_W-1:0] r2_der;

    // stage 3: products, integral term split in two 20-bit halves
    logic [DIST_W-1:0]  r3_dist;
    logic signed [44:0] r3_pkp;
    logic signed [45:0] r3_pkd;
    logic [43:0]        r3_pilo;
    logic signed [44:0] r3_pihi;

    // stage 4: sum, floor to signed Q24.8, saturate
    logic signed [64:0] w_ihi_sh;
    logic signed [66:0] w_total;
    logic signed [50:0] w_drive_full;
    logic signed [DRIVE_W-1:0] n_drive;

    logic [DIST_W-1:0]         r4_dist;
    logic signed [DRIVE_W-1:0] r4_drive;

    assign w_en4   = !r_v4 || i_ready;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign o_ready = w_en2;

    assign w_err_full = $signed({5'd0, i_cfg.target_distance}) - $signed({2'd0, i_dist});
    assign w_err      = w_err_full[ERR_W-1:0];
    assign w_sum_full = 41'(r_error_sum) - 41'(w_err);
    assign w_der      = 21'(w_err) - 21'(r_prev_error);

    always_comb begin
        if (w_sum_full > SUM_MAX) begin
            n_error_sum = SUM_MAX[SUM_W-1:0];
        end else if (w_sum_full < SUM_MIN) begin
            n_error_sum = SUM_MIN[SUM_W-1:0];
        end else begin
            n_error_sum = w_sum_full[SUM_W-1:0];
        end
    end

    assign w_ihi_sh     = {r3_pihi, 20'd0};
    assign w_total      = 67'(r3_pkp) + 67'(r3_pkd) + $signed({23'd0, r3_pilo})
                        + 67'(w_ihi_sh);
    assign w_drive_full = w_total[66:16];

    always_comb begin
        if (w_drive_full > DRV_MAX) begin
            n_drive = DRV_MAX[DRIVE_W-1:0];
        end else if (w_drive_full < DRV_MIN) begin
            n_drive = DRV_MIN[DRIVE_W-1:0];
        end else begin
            n_drive = w_drive_full[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_error_sum  <= '0;
            r_prev_error <= '0;
        end else begin
            if (w_en2) begin
                r_v2 <= i_valid;
                if (i_valid) begin
                    r_error_sum  <= n_error_sum;
                    r_prev_error <= w_err;
                end
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && i_valid) begin
            r2_dist <= i_dist;
            r2_err  <= w_err;
            r2_sum  <= n_error_sum;
            r2_der  <= w_der;
        end
        if (w_en3 && r_v2) begin
            r3_dist <= r2_dist;
            r3_pkp  <= $signed({1'b0, i_cfg.kp_gain}) * r2_err;
            r3_pkd  <= $signed({1'b0, i_cfg.kd_gain}) * r2_der;
            r3_pilo <= {20'd0, i_cfg.ki_gain} * {24'd0, r2_sum[19:0]};
            r3_pihi <= $signed({1'b0, i_cfg.ki_gain}) * $signed(r2_sum[39:20]);
        end
        if (w_en4 && r_v3) begin
            r4_dist  <= r3_dist;
            r4_drive <= n_drive;
        end
    end

    assign o_valid = r_v4;
    assign o_dist  = r4_dist;
    assign o_drive = r4_drive;

    a_state_moves_on_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (!$stable(r_error_sum) || !$stable(r_prev_error))
        |-> $past(w_en2 && i_valid))
        else $error("integrator state changed without an item");

endmodule

>>> hdl/eds_servo.sv
module eds_servo
    import eds_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [DIST_W-1:0]         i_dist,
    input  logic signed [DRIVE_W-1:0] i_drive,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [DIST_W-1:0]         o_dist,
    output logic signed [DRIVE_W-1:0] o_drive,
    output logic [ANGLE_W-1:0]        o_angle,
    output logic [CMP_W-1:0]          o_compare
);

    logic [ANGLE_W-1:0] r_angle_now;
    logic               r_valid;
    logic               w_en;

    logic signed [33:0] w_angle_raw;
    logic [ANGLE_W-1:0] n_angle;

    logic [DIST_W-1:0]         r_dist;
    logic signed [DRIVE_W-1:0] r_drive;
    logic [CMP_W-1:0]          r_compare;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    assign w_angle_raw = $signed({18'd0, r_angle_now}) - 34'(i_drive);

    // lower bound is tested first, so min above max still gives min for low values
    always_comb begin
        if (w_angle_raw < $signed({18'd0, i_cfg.angle_min})) begin
            n_angle = i_cfg.angle_min;
        end else if (w_angle_raw > $signed({18'd0, i_cfg.angle_max})) begin
            n_angle = i_cfg.angle_max;
        end else begin
            n_angle = w_angle_raw[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_angle_now <= ANGLE_RESET;
        end else if (w_en) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_angle_now <= n_angle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_dist    <= i_dist;
            r_drive   <= i_drive;
            r_compare <= {1'b0, n_angle[15:8]} + {1'b0, i_cfg.servo_offset};
        end
    end

    assign o_valid   = r_valid;
    assign o_dist    = r_dist;
    assign o_drive   = r_drive;
    assign o_angle   = r_angle_now;
    assign o_compare = r_compare;

    a_angle_moves_on_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$stable(r_angle_now) |-> $past(w_en && i_valid))
        else $error("servo angle changed without an item");

endmodule

>>> hdl/echo_distance_pid_servo_core.sv
// channel   | dir | signals             | contents (low bit up)
// s_axis    | in  | tvalid tready tdata | echo_count[15:0]
// m_axis    | out | tvalid tready tdata | distance_q8[18:0] drive_value[50:19]
//           |     |                     | servo_angle[66:51] servo_compare[75:67]
// cfg       | in  | wr_en index data    | register index 0..6, data 24 bits
//
// One transfer per cycle sustained while m_axis accepts; stages in order: distance multiply,
// error and integrator update, gain multiplies, drive sum/saturate, angle clamp.
// Integrator and angle recurrences each close inside one stage.
// Synchronous active-low reset clears pipeline, state and registers to defaults.
// Stages advance independently, so bubbles collapse; s_axis_tready falls only when
// every stage is full and m_axis is stalled.
module echo_distance_pid_servo_core
    import eds_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,   // echo_count[15:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // distance_q8[18:0], drive_value[50:19], servo_angle[66:51], servo_compare[75:67]
    output logic [79:0]           m_axis_tdata
);

    t_cfg r_cfg;

    logic              w_dist_valid, w_dist_ready;
    logic [DIST_W-1:0] w_dist;

    logic                      w_pid_valid, w_pid_ready;
    logic [DIST_W-1:0]         w_pid_dist;
    logic signed [DRIVE_W-1:0] w_pid_drive;

    logic [DIST_W-1:0]         w_out_dist;
    logic signed [DRIVE_W-1:0] w_out_drive;
    logic [ANGLE_W-1:0]        w_out_angle;
    logic [CMP_W-1:0]          w_out_compare;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain         <= KP_RESET;
            r_cfg.ki_gain         <= KI_RESET;
            r_cfg.kd_gain         <= KD_RESET;
            r_cfg.target_distance <= TARGET_RESET;
            r_cfg.angle_min       <= AMIN_RESET;
            r_cfg.angle_max       <= AMAX_RESET;
            r_cfg.servo_offset    <= OFFSET_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_KP_GAIN:      r_cfg.kp_gain         <= i_cfg_data;
                CFG_KI_GAIN:      r_cfg.ki_gain         <= i_cfg_data;
                CFG_KD_GAIN:      r_cfg.kd_gain         <= i_cfg_data;
                CFG_TARGET:       r_cfg.target_distance <= i_cfg_data[15:0];
                CFG_ANGLE_MIN:    r_cfg.angle_min       <= i_cfg_data[15:0];
                CFG_ANGLE_MAX:    r_cfg.angle_max       <= i_cfg_data[15:0];
                CFG_SERVO_OFFSET: r_cfg.servo_offset    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    eds_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_count (s_axis_tdata),
        .o_valid (w_dist_valid),
        .i_ready (w_dist_ready),
        .o_dist  (w_dist)
    );

    eds_pid u_pid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_dist_valid),
        .o_ready (w_dist_ready),
        .i_dist  (w_dist),
        .o_valid (w_pid_valid),
        .i_ready (w_pid_ready),
        .o_dist  (w_pid_dist),
        .o_drive (w_pid_drive)
    );

    eds_servo u_servo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (w_pid_valid),
        .o_ready   (w_pid_ready),
        .i_dist    (w_pid_dist),
        .i_drive   (w_pid_drive),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_dist    (w_out_dist),
        .o_drive   (w_out_drive),
        .o_angle   (w_out_angle),
        .o_compare (w_out_compare)
    );

    assign m_axis_tdata = {4'd0, w_out_compare, w_out_angle, w_out_drive, w_out_dist};

    a_stall_only_downstream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output side is free");

endmodule

>>> tb/echo_distance_pid_servo_core_tb.sv
`timescale 1ns / 1ps

module echo_distance_pid_servo_core_tb
    import eds_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;
    localparam int     ECHO_DIVISOR = 58;
    localparam longint SUM_HI       = 64'sd549755813887;
    localparam longint SUM_LO       = -64'sd549755813888;
    localparam longint DRIVE_HI     = 64'sd2147483647;
    localparam longint DRIVE_LO     = -64'sd2147483648;
    localparam int     CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [3:0]           pad;
        logic [CMP_W-1:0]     cmp;
        logic [ANGLE_W-1:0]   angle;
        logic [DRIVE_W-1:0]   drive;
        logic [DIST_W-1:0]    distance;
    } t_servo_word;

    class pid_scoreboard;
        t_cfg                     regs;
        logic signed [SUM_W-1:0]  integ;
        logic signed [ERR_W-1:0]  last_err;
        logic [ANGLE_W-1:0]       angle;
        t_servo_word              pending[$];
        int                       errors;

        function new();
            regs.kp_gain         = KP_RESET;
            regs.ki_gain         = KI_RESET;
            regs.kd_gain         = KD_RESET;
            regs.target_distance = TARGET_RESET;
            regs.angle_min       = AMIN_RESET;
            regs.angle_max       = AMAX_RESET;
            regs.servo_offset    = OFFSET_RESET;
            integ    = '0;
            last_err = '0;
            angle    = ANGLE_RESET;
            errors   = 0;
        endfunction

        function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_KP_GAIN:      regs.kp_gain = data;
                CFG_KI_GAIN:      regs.ki_gain = data;
                CFG_KD_GAIN:      regs.kd_gain = data;
                CFG_TARGET:       regs.target_distance = data[15:0];
                CFG_ANGLE_MIN:    regs.angle_min = data[15:0];
                CFG_ANGLE_MAX:    regs.angle_max = data[15:0];
                CFG_SERVO_OFFSET: regs.servo_offset = data[7:0];
                default: ;
            endcase
        endfunction

        function void note_echo(logic [COUNT_W-1:0] count);
            longint dist_q8, err, sum, der, drv, ang;
            logic signed [79:0] kp_w, ki_w, kd_w, e_w, s_w, d_w, acc;
            t_servo_word w;
            dist_q8 = (longint'(count) * 256) / ECHO_DIVISOR;
            err = longint'(regs.target_distance) - dist_q8;
            sum = longint'(integ) - err;
            if (sum > SUM_HI) sum = SUM_HI;
            if (sum < SUM_LO) sum = SUM_LO;
            integ = sum[SUM_W-1:0];
            der = err - longint'(last_err);
            last_err = err[ERR_W-1:0];
            kp_w = 80'(regs.kp_gain);
            ki_w = 80'(regs.ki_gain);
            kd_w = 80'(regs.kd_gain);
            e_w  = 80'(err);
            s_w  = 80'(sum);
            d_w  = 80'(der);
            acc  = (kp_w * e_w + ki_w * s_w + kd_w * d_w) >>> 16;
            if (acc > DRIVE_HI) drv = DRIVE_HI;
            else if (acc < DRIVE_LO) drv = DRIVE_LO;
            else drv = longint'(acc);
            ang = longint'(angle) - drv;
            // lower bound wins when min is above max
            if (ang < longint'(regs.angle_min)) ang = longint'(regs.angle_min);
            else if (ang > longint'(regs.angle_max)) ang = longint'(regs.angle_max);
            angle = ang[ANGLE_W-1:0];
            w.pad      = '0;
            w.distance = dist_q8[DIST_W-1:0];
            w.drive    = drv[DRIVE_W-1:0];
            w.angle    = angle;
            w.cmp      = {1'b0, angle[15:8]} + {1'b0, regs.servo_offset};
            pending.push_back(w);
        endfunction

        function void check_result(logic [79:0] word);
            t_servo_word got, want;
            got = word;
            if (pending.size() == 0) begin
                $error("result transfer with nothing pending: %h", word);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.distance !== want.distance) begin
                $error("distance_q8 expected %0d actual %0d", want.distance, got.distance);
                errors++;
            end
            if (got.drive !== want.drive) begin
                $error("drive_value expected %0d actual %0d",
                       $signed(want.drive), $signed(got.drive));
                errors++;
            end
            if (got.angle !== want.angle) begin
                $error("servo_angle expected %0d actual %0d", want.angle, got.angle);
                errors++;
            end
            if (got.cmp !== want.cmp) begin
                $error("servo_compare expected %0d actual %0d", want.cmp, got.cmp);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [79:0]           m_axis_tdata;

    pid_scoreboard sb;
    bit            full_rate = 1'b0;
    int            cycles = 0;
    logic [15:0]   corner_echoes[$] = '{16'd0, 16'd65535, 16'd1, 16'd65534, 16'd21845,
                                        16'd43690, 16'd57, 16'd58, 16'd59, 16'd632,
                                        16'd633, 16'd631, 16'd32768, 16'd32767,
                                        16'd255, 16'd65280, 16'd0, 16'd0};

    echo_distance_pid_servo_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_echo(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("echo_distance_pid_servo_core_tb NOT OK");
            $finish;
        end
    end

    initial begin : sink_pacing
        int pick;
        int span;
        @(posedge i_clk);
        forever begin
            pick = $urandom_range(99);
            if (full_rate || pick < 60) begin
                m_axis_tready <= 1'b1;
                span = full_rate ? 1 : $urandom_range(20, 1);
            end else if (pick < 92) begin
                m_axis_tready <= 1'b0;
                span = $urandom_range(3, 1);
            end else begin
                m_axis_tready <= 1'b0;
                span = $urandom_range(40, 10);
            end
            repeat (span) @(posedge i_clk);
        end
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(3, 1);
        if (pick < 95) return $urandom_range(10, 4);
        return $urandom_range(50, 20);
    endfunction

    task automatic send_echo(input logic [15:0] count, input bit idle);
        int gap;
        gap = idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= count;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic configure(input logic [23:0] kp_val, input logic [23:0] ki_val,
                             input logic [23:0] kd_val, input logic [23:0] tgt_val,
                             input logic [23:0] lo_val, input logic [23:0] hi_val,
                             input logic [23:0] off_val, input bit poke_unmapped);
        logic [CFG_DATA_W-1:0] plan [0:7];
        int last;
        plan[CFG_KP_GAIN]      = kp_val;
        plan[CFG_KI_GAIN]      = ki_val;
        plan[CFG_KD_GAIN]      = kd_val;
        plan[CFG_TARGET]       = tgt_val;
        plan[CFG_ANGLE_MIN]    = lo_val;
        plan[CFG_ANGLE_MAX]    = hi_val;
        plan[CFG_SERVO_OFFSET] = off_val;
        plan[CFG_UNMAPPED]     = CFG_DATA_W'($urandom());
        last = poke_unmapped ? int'(CFG_UNMAPPED) : int'(CFG_SERVO_OFFSET);
        for (int idx = 0; idx <= last; idx++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(idx);
            i_cfg_data  <= plan[idx];
            @(posedge i_clk);
            sb.load_reg(CFG_IDX_W'(idx), plan[idx]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int n, input int lo, input int hi, input bit idle);
        logic [15:0] count;
        full_rate = !idle;
        repeat (n) begin
            count = 16'($urandom_range(hi, lo));
            if ($urandom_range(15) == 0) count = $urandom_range(1) ? hi[15:0] : lo[15:0];
            send_echo(count, idle);
        end
        drain();
        full_rate = 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_echoes[k]) send_echo(corner_echoes[k], 1'b1);
        drain();

        // integral driven far negative until the drive clips low
        configure(24'd0, 24'hFFFFFF, 24'd0, 24'h00FFFF, 24'd0, 24'd46080, 24'd0, 1'b0);
        run_phase(200, 0, 30, 1'b1);

        // swing back until the drive clips high, full rate on both sides
        configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 24'd65535, 24'd255, 1'b0);
        run_phase(100, 60000, 65535, 1'b0);

        // min above max, plus a write to an unmapped index
        configure(KP_RESET, KI_RESET, KD_RESET, 24'(TARGET_RESET), 24'd30000, 24'd10000,
                  24'd100, 1'b1);
        run_phase(60, 0, 65535, 1'b1);

        configure(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
                  24'($urandom()), 24'($urandom()), 24'($urandom()), 1'b1);
        run_phase(70, 0, 65535, 1'b1);

        configure(KP_RESET, KI_RESET, KD_RESET, 24'(TARGET_RESET), 24'(AMIN_RESET),
                  24'(AMAX_RESET), 24'(OFFSET_RESET), 1'b0);
        run_phase(80, 500, 800, 1'b1);

        configure(24'($urandom_range(131072)), 24'($urandom_range(64)),
                  24'($urandom_range(131072)), 24'($urandom_range(65535)),
                  24'($urandom_range(23040)), 24'($urandom_range(46080, 23040)),
                  24'($urandom_range(255)), 1'b0);
        run_phase(50, 0, 65535, 1'b1);

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("echo_distance_pid_servo_core_tb OK");
        else
            $display("echo_distance_pid_servo_core_tb NOT OK");
        $finish;
    end

endmodule
